>>> src/swp_llc_act_shdlc_engine_top_defines.svh
// ----------------------------------------------------------------------------
// SWP LLC engine assertion macros
// Concurrent assertion wrappers, empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef SWP_LLC_ACT_SHDLC_ENGINE_TOP_DEFINES_SVH
`define SWP_LLC_ACT_SHDLC_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// clocked assertion, disabled during reset
`define SWPLLC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked assertion, also checked during reset
`define SWPLLC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWPLLC_ASSERT(lbl, clk, rst, prop, msg)
`define SWPLLC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> src/swpllc_pkg.sv
// ----------------------------------------------------------------------------
// SWP LLC engine package
// Shared widths, codes, configuration and job types.
// ----------------------------------------------------------------------------
package swpllc_pkg;

   localparam int unsigned MAX_TX_BYTES = 6;
   localparam int unsigned TX_IDX_W     = $clog2(MAX_TX_BYTES);
   localparam int unsigned QUEUE_DEPTH  = 2;
   localparam int unsigned QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned CSR_INDEX_W  = 3;
   localparam int unsigned CSR_DATA_W   = 16;

   // request types
   localparam logic [1:0] REQ_ACTIVATE   = 2'd0;
   localparam logic [1:0] REQ_DEACTIVATE = 2'd1;
   localparam logic [1:0] REQ_FRAME      = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_WINDOW     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCAL_VERSION  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUPPORTED_LLCS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FRAME_SIZE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_MODES    = 3'd4;

   // send kinds
   localparam logic [2:0] KIND_SYNC    = 3'd0;
   localparam logic [2:0] KIND_REPEAT  = 3'd1;
   localparam logic [2:0] KIND_READY   = 3'd2;
   localparam logic [2:0] KIND_UA      = 3'd3;
   localparam logic [2:0] KIND_REJ     = 3'd4;
   localparam logic [2:0] KIND_RR      = 3'd5;
   localparam logic [2:0] KIND_IHEADER = 3'd6;
   localparam logic [2:0] KIND_DROPPED = 3'd7;

   // link phases
   localparam logic [2:0] PHASE_CLOSED      = 3'd0;
   localparam logic [2:0] PHASE_SYNC_SENT   = 3'd2;
   localparam logic [2:0] PHASE_READY_SENT  = 3'd3;
   localparam logic [2:0] PHASE_ESTABLISHED = 3'd4;

   // frame codes
   localparam logic [7:0] SYNC_FRAME_ID  = 8'h01;
   localparam logic [7:0] PWR_MODE_CTRL  = 8'h02;
   localparam logic [7:0] READY_FRAME_ID = 8'h03;
   localparam logic [2:0] HEAD_S_FRAME   = 3'b110;
   localparam logic [2:0] HEAD_U_FRAME   = 3'b111;
   localparam logic [4:0] U_RSET         = 5'h19;
   localparam logic [7:0] U_UA_BYTE      = 8'hE6;
   localparam logic [4:0] S_REJ_HEAD     = 5'b11001;
   localparam logic [4:0] S_RR_HEAD      = 5'b11000;
   localparam logic [1:0] I_HEAD         = 2'b10;
   localparam logic [8:0] APP_LEN_MAX    = 9'd511;

   typedef struct packed {
      logic [2:0]  max_window;
      logic [7:0]  local_version;
      logic [7:0]  supported_llcs;
      logic [15:0] max_frame_size;
      logic [7:0]  power_modes;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      max_window:     3'd4,
      local_version:  8'd1,
      supported_llcs: 8'h05,
      max_frame_size: 16'd256,
      power_modes:    8'h03
   };

   typedef struct packed {
      logic [MAX_TX_BYTES-1:0][7:0] tx_bytes;
      logic [TX_IDX_W-1:0]          count;      // 1..MAX_TX_BYTES
      logic [2:0]                   send_kind;
      logic [8:0]                   app_length;
      logic [2:0]                   link_state;
      logic                         full_power_mode;
   } job_type;

   typedef struct packed {
      logic full;
      logic head_valid;
   } queue_status_type;

endpackage

>>> src/swpllc_if.sv
// ----------------------------------------------------------------------------
// SWP LLC engine channels
// Request and response valid/ready channels.
// ----------------------------------------------------------------------------
interface swpllc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [7:0]  control_byte;
   logic [7:0]  first_param;
   logic [15:0] frame_length;

   modport source (output valid, req_type, control_byte, first_param, frame_length,
                   input ready);
   modport sink   (input valid, req_type, control_byte, first_param, frame_length,
                   output ready);
endinterface

interface swpllc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       tx_last;
   logic [2:0] send_kind;
   logic [8:0] app_length;
   logic [2:0] link_state;
   logic       full_power_mode;

   modport source (output valid, tx_byte, tx_last, send_kind, app_length, link_state,
                   full_power_mode, input ready);
   modport sink   (input valid, tx_byte, tx_last, send_kind, app_length, link_state,
                   full_power_mode, output ready);
endinterface

>>> src/swpllc_front.sv
// ----------------------------------------------------------------------------
// SWP LLC front end
// Accepts requests, runs the ACT/SHDLC link state and queues transmit jobs.
// ----------------------------------------------------------------------------
module swpllc_front
   import swpllc_pkg::*;
#(
   parameter int unsigned MAX_FRAME_BYTES = 272
) (
   input  logic             clock,
   input  logic             reset,
   swpllc_req_if.sink       req,
   input  cfg_type          cfg,
   input  queue_status_type q_status,
   output logic             push,
   output job_type          push_job
);

   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  sn_ff, sn_in;
   logic [2:0]  nr_ff, nr_in;
   logic        open_ff, open_in;
   logic [2:0]  window_ff, window_in;
   logic        power_ff, power_in;
   logic [3:0]  store_len_ff, store_len_in;
   logic [MAX_TX_BYTES-1:0][7:0] act_store_ff;
   logic        store_we;
   logic [TX_IDX_W-1:0] store_cnt;
   logic        accept;
   logic [7:0]  param;
   logic [15:0] app_raw;
   logic [2:0]  nr_next;
   logic [2:0]  win_pick;
   job_type     job;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      phase_in     = phase_ff;
      sn_in        = sn_ff;
      nr_in        = nr_ff;
      open_in      = open_ff;
      window_in    = window_ff;
      power_in     = power_ff;
      store_len_in = store_len_ff;
      store_we     = 1'b0;
      push         = 1'b0;
      job          = '0;
      job.count    = TX_IDX_W'(1);
      param        = (req.frame_length <= 16'd1) ? 8'd0 : req.first_param;
      app_raw      = req.frame_length - 16'd1;
      nr_next      = nr_ff + 3'd1;
      win_pick     = cfg.max_window;
      store_cnt    = TX_IDX_W'(store_len_ff);

      if (accept) begin
         unique case (req.req_type)
            REQ_ACTIVATE: begin
               sn_in = '0; nr_in = '0; open_in = 1'b0; window_in = cfg.max_window;
               phase_in         = PHASE_SYNC_SENT;
               job.tx_bytes[0]  = SYNC_FRAME_ID;
               job.tx_bytes[1]  = cfg.local_version;
               job.tx_bytes[2]  = cfg.supported_llcs;
               job.tx_bytes[3]  = cfg.max_frame_size[15:8];
               job.tx_bytes[4]  = cfg.max_frame_size[7:0];
               job.tx_bytes[5]  = cfg.power_modes;
               job.count        = TX_IDX_W'(MAX_TX_BYTES);
               job.send_kind    = KIND_SYNC;
               store_we         = 1'b1;
               store_len_in     = 4'(MAX_TX_BYTES);
               push             = 1'b1;
            end
            REQ_DEACTIVATE: begin
               sn_in = '0; nr_in = '0; open_in = 1'b0; window_in = cfg.max_window;
               store_len_in = '0;
               phase_in     = PHASE_CLOSED;
            end
            REQ_FRAME: begin
               if (req.frame_length == 16'd0) begin
                  // empty frame: nothing to do
               end else if (req.frame_length > 16'(MAX_FRAME_BYTES)) begin
                  job.send_kind = KIND_DROPPED;
                  push          = 1'b1;
               end else if (!req.control_byte[7]) begin
                  // ACT layer
                  if (req.control_byte == PWR_MODE_CTRL) begin
                     if (param[1]) begin
                        if (store_len_ff != 4'd0) begin
                           job.tx_bytes  = act_store_ff;
                           job.count     = store_cnt;
                           job.send_kind = KIND_REPEAT;
                           push          = 1'b1;
                        end
                     end else begin
                        power_in        = param[0];
                        phase_in        = PHASE_READY_SENT;
                        job.tx_bytes[0] = READY_FRAME_ID;
                        job.send_kind   = KIND_READY;
                        store_we        = 1'b1;
                        store_len_in    = 4'd1;
                        push            = 1'b1;
                     end
                  end
               end else if (req.control_byte[7:5] == HEAD_U_FRAME) begin
                  if (req.control_byte[4:0] == U_RSET) begin
                     if (req.frame_length > 16'd1 && req.first_param < {5'd0, cfg.max_window})
                        win_pick = req.first_param[2:0];
                     if (win_pick == 3'd0)
                        win_pick = 3'd1;
                     sn_in = '0; nr_in = '0; store_len_in = '0;
                     window_in       = win_pick;
                     open_in         = 1'b1;
                     phase_in        = PHASE_ESTABLISHED;
                     job.tx_bytes[0] = U_UA_BYTE;
                     job.tx_bytes[1] = {5'd0, win_pick};
                     job.tx_bytes[2] = 8'd0;
                     job.count       = TX_IDX_W'(3);
                     job.send_kind   = KIND_UA;
                     push            = 1'b1;
                  end
               end else if (req.control_byte[7:5] != HEAD_S_FRAME && open_ff) begin
                  push = 1'b1;
                  if (req.control_byte[5:3] != nr_ff) begin
                     job.tx_bytes[0] = {S_REJ_HEAD, nr_ff};
                     job.send_kind   = KIND_REJ;
                  end else begin
                     nr_in = nr_next;
                     if (app_raw == 16'd0) begin
                        job.tx_bytes[0] = {S_RR_HEAD, nr_next};
                        job.send_kind   = KIND_RR;
                     end else begin
                        job.tx_bytes[0] = {I_HEAD, sn_ff, nr_next};
                        job.send_kind   = KIND_IHEADER;
                        job.app_length  = (app_raw > 16'(APP_LEN_MAX)) ? APP_LEN_MAX
                                                                       : app_raw[8:0];
                        sn_in           = sn_ff + 3'd1;
                     end
                  end
               end
            end
            default: begin
               // unknown request type: ignored
            end
         endcase
      end

      job.link_state      = phase_in;
      job.full_power_mode = power_in;
   end

   assign push_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_CLOSED;
         sn_ff        <= '0;
         nr_ff        <= '0;
         open_ff      <= 1'b0;
         window_ff    <= CFG_RESET.max_window;
         power_ff     <= 1'b0;
         store_len_ff <= '0;
      end else begin
         phase_ff     <= phase_in;
         sn_ff        <= sn_in;
         nr_ff        <= nr_in;
         open_ff      <= open_in;
         window_ff    <= window_in;
         power_ff     <= power_in;
         store_len_ff <= store_len_in;
      end
   end

   // last ACT frame, kept for repeat requests
   always_ff @(posedge clock) begin
      if (store_we) begin
         for (int i = 0; i < MAX_TX_BYTES; i++) begin
            if (i < int'(job.count))
               act_store_ff[i] <= job.tx_bytes[i];
         end
      end
   end

endmodule

>>> src/swpllc_fifo.sv
// ----------------------------------------------------------------------------
// SWP LLC job queue
// Short queue of transmit jobs between front and back ends.
// ----------------------------------------------------------------------------
module swpllc_fifo
   import swpllc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output queue_status_type status,
   output job_type          head_job
);

   job_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic                   do_push, do_pop;

   assign status.full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.head_valid = (count_ff != '0);
   assign do_push           = push && !status.full;
   assign do_pop            = pop && status.head_valid;
   assign head_job          = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push)
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (do_pop)
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         if (do_push && !do_pop)
            count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push)
            count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         mem_ff[wr_ptr_ff] <= push_job;
   end

endmodule

>>> src/swpllc_back.sv
// ----------------------------------------------------------------------------
// SWP LLC back end
// Serialises queued jobs into transmit bytes through an output register.
// ----------------------------------------------------------------------------
`include "swp_llc_act_shdlc_engine_top_defines.svh"

module swpllc_back
   import swpllc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  job_type          head_job,
   output logic             pop,
   swpllc_rsp_if.source     rsp
);

   logic [TX_IDX_W-1:0] idx_ff, idx_in;
   logic                valid_ff, valid_in;
   logic [7:0]          byte_ff;
   logic                last_ff;
   logic [2:0]          kind_ff;
   logic [8:0]          applen_ff;
   logic [2:0]          state_ff;
   logic                power_ff;
   logic                load, is_last;

   assign load    = q_status.head_valid && (!valid_ff || rsp.ready);
   assign is_last = (idx_ff == head_job.count - 1'b1);
   assign pop     = load && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = is_last ? '0 : idx_ff + 1'b1;
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= head_job.tx_bytes[idx_ff];
         last_ff   <= is_last;
         kind_ff   <= head_job.send_kind;
         applen_ff <= head_job.app_length;
         state_ff  <= head_job.link_state;
         power_ff  <= head_job.full_power_mode;
      end
   end

   assign rsp.valid           = valid_ff;
   assign rsp.tx_byte         = byte_ff;
   assign rsp.tx_last         = last_ff;
   assign rsp.send_kind       = kind_ff;
   assign rsp.app_length      = applen_ff;
   assign rsp.link_state      = state_ff;
   assign rsp.full_power_mode = power_ff;

   `SWPLLC_ASSERT(a_idx_in_job, clock, reset, q_status.head_valid |-> idx_ff < head_job.count, "byte index beyond job length")
   `SWPLLC_ASSERT(a_drop_single, clock, reset, (valid_ff && kind_ff == KIND_DROPPED) |-> (last_ff && byte_ff == 8'd0), "dropped marker malformed")
   `SWPLLC_ASSERT(a_applen_ihdr, clock, reset, (valid_ff && applen_ff != 9'd0) |-> (kind_ff == KIND_IHEADER), "app length on non I header")
   `SWPLLC_ASSERT_ALWAYS(a_idx_reset, clock, $past(reset) |-> idx_ff == '0 && !valid_ff, "back end not cleared by reset")

endmodule

>>> src/swp_llc_act_shdlc_engine_top.sv
// Path: an accepted item is written into the job queue, then its first byte into the output register.
// Throughput: one transmit byte per cycle while the receiver is ready; an item of n bytes
//   (1..6) holds the back end until its last byte is loaded; the front end takes one request
//   per cycle into a two-entry job queue unless it is full. Byteless items skip the queue.
// Reset: synchronous, active high; link state, queue and output register are cleared and
//   the registers return to their default values. No clearing pass.
// ----------------------------------------------------------------------------
// SWP LLC ACT/SHDLC engine
// Card-side link layer: ACT activation plus modulo-8 SHDLC sequencing.
// ----------------------------------------------------------------------------
module swp_llc_act_shdlc_engine_top
   import swpllc_pkg::*;
#(
   parameter int unsigned MAX_FRAME_BYTES = 272  // frames longer than this are dropped
) (
   input  logic                   clock,
   input  logic                   reset,
   swpllc_req_if.sink             req,
   swpllc_rsp_if.source           rsp,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Configuration registers. Writes must arrive only while the engine is idle; nothing
   // checks this; the front end uses them directly for the sync frame and window clamp.
   cfg_type          cfg_ff, cfg_in;

   // Front to queue: one job per transaction that causes transmit bytes.
   logic             push;
   job_type          push_job;

   // Queue to back end.
   queue_status_type q_status;
   job_type          head_job;
   logic             pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_WINDOW:     cfg_in.max_window     = csr_wdata[2:0];
            CSR_LOCAL_VERSION:  cfg_in.local_version  = csr_wdata[7:0];
            CSR_SUPPORTED_LLCS: cfg_in.supported_llcs = csr_wdata[7:0];
            CSR_MAX_FRAME_SIZE: cfg_in.max_frame_size = csr_wdata;
            CSR_POWER_MODES:    cfg_in.power_modes    = csr_wdata[7:0];
            default: begin
               // unmapped index: write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: decodes each request, advances phase / N(S) / N(R) / window and
   // power state at acceptance, and hands a fully formed job to the queue.
   swpllc_front #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .cfg      (cfg_ff),
      .q_status (q_status),
      .push     (push),
      .push_job (push_job)
   );

   // Job queue: decouples request acceptance from byte serialisation.
   swpllc_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .status   (q_status),
      .head_job (head_job)
   );

   // Back end: walks the head job byte by byte into the response register.
   swpllc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .head_job (head_job),
      .pop      (pop),
      .rsp      (rsp)
   );

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SWP LLC ACT/SHDLC engine testbench
// Drives activate, deactivate and received-frame transactions into the engine,
// predicts every transmitted byte from a local copy of the link state and
// configuration, and checks each response transaction field by field. Directed
// cases cover the corner cases and register extremes; random sessions then
// work through ACT set-up, RSET and I-frame sequencing under random stalls.
// ----------------------------------------------------------------------------
module tb_top;
   import swpllc_pkg::*;

   // frames above this length are dropped by the engine
   localparam int FRAME_LIMIT    = 272;
   // quiet cycles allowed before the run is declared hung
   localparam int WATCHDOG_LIMIT = 2000;
   // cycles left after the last byte so that silent items can retire
   localparam int SETTLE_CYCLES  = 12;
   // length of the forced receiver hold-off
   localparam int HOLD_CYCLES    = 80;

   // request type the engine does not know
   localparam logic [1:0] REQ_UNKNOWN      = 2'd3;
   // power-mode parameter bits
   localparam logic [7:0] PARAM_FULL_POWER = 8'h01;
   localparam logic [7:0] PARAM_FR         = 8'h02;
   // RSET control byte
   localparam logic [7:0] RSET_CTRL        = {HEAD_U_FRAME, U_RSET};

   // one transmitted byte as seen on the response channel
   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_last;
      logic [2:0] send_kind;
      logic [8:0] app_length;
      logic [2:0] link_state;
      logic       full_power_mode;
   } tx_beat_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   swpllc_req_if req_ch ();
   swpllc_rsp_if rsp_ch ();

   swp_llc_act_shdlc_engine_top #(
      .MAX_FRAME_BYTES (FRAME_LIMIT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // --------------------------------------------------------------------------
   // Predicted link state and register copy
   // --------------------------------------------------------------------------
   cfg_type          cfg_shadow   = CFG_RESET;
   logic [2:0]       lk_phase     = PHASE_CLOSED;
   logic [2:0]       lk_ns        = 3'd0;   // next N(S) we send
   logic [2:0]       lk_nr        = 3'd0;   // N(S) we expect next
   logic             lk_open      = 1'b0;
   logic [2:0]       lk_window    = CFG_RESET.max_window;
   logic             lk_power     = 1'b0;
   logic [0:7][7:0]  act_bytes    = '0;     // last ACT frame, for repeats
   int               act_len      = 0;

   tx_beat_type      tx_pending[$];         // bytes still owed by the engine
   int unsigned      beats_predicted = 0;
   int unsigned      answered_items  = 0;   // items that drew at least one byte
   int unsigned      errors          = 0;

   // idling control, shared with the receiver process
   int unsigned      src_idle_pct  = 0;
   int unsigned      snk_stall_pct = 0;
   bit               hold_request  = 1'b0;
   int unsigned      hold_left     = 0;
   int unsigned      quiet_cycles  = 0;

   function automatic void push_beat(input logic [7:0] b, input logic last,
                                     input logic [2:0] kind, input logic [8:0] alen);
      tx_beat_type e;
      e.tx_byte         = b;
      e.tx_last         = last;
      e.send_kind       = kind;
      e.app_length      = alen;
      e.link_state      = lk_phase;
      e.full_power_mode = lk_power;
      tx_pending.push_back(e);
      beats_predicted++;
   endfunction

   // emits a frame; ACT frames are also kept for a later repeat
   function automatic void push_frame(input logic [0:7][7:0] fb, input int n,
                                      input logic [2:0] kind, input bit keep);
      if (keep) begin
         for (int i = 0; i < n; i++) act_bytes[i] = fb[i];
         act_len = n;
      end
      for (int i = 0; i < n; i++) push_beat(fb[i], i == n - 1, kind, 9'd0);
   endfunction

   // link reset leaves phase and power flag alone
   function automatic void reset_link();
      lk_ns     = 3'd0;
      lk_nr     = 3'd0;
      lk_open   = 1'b0;
      lk_window = cfg_shadow.max_window;
      act_len   = 0;
   endfunction

   // works out the bytes one accepted request makes the engine transmit
   function automatic void compute_tx_bytes(input logic [1:0] t, input logic [7:0] c,
                                            input logic [7:0] p, input logic [15:0] l);
      logic [0:7][7:0] fb;
      logic [7:0]      prm;
      logic [2:0]      w;
      logic [8:0]      alen;
      int              dlen;
      fb  = '0;
      prm = p;
      case (t)
         REQ_ACTIVATE: begin
            reset_link();
            lk_phase = PHASE_SYNC_SENT;
            fb[0] = SYNC_FRAME_ID;
            fb[1] = cfg_shadow.local_version;
            fb[2] = cfg_shadow.supported_llcs;
            fb[3] = cfg_shadow.max_frame_size[15:8];
            fb[4] = cfg_shadow.max_frame_size[7:0];
            fb[5] = cfg_shadow.power_modes;
            push_frame(fb, 6, KIND_SYNC, 1'b1);
         end
         REQ_DEACTIVATE: begin
            reset_link();
            lk_phase = PHASE_CLOSED;
         end
         REQ_FRAME: begin
            if (l == 16'd0) begin
               // empty frame: nothing
            end else if (l > FRAME_LIMIT) begin
               push_beat(8'h00, 1'b1, KIND_DROPPED, 9'd0);
            end else if (!c[7]) begin
               // ACT layer; only power-mode frames matter
               if (c == PWR_MODE_CTRL) begin
                  if (l == 16'd1) prm = 8'h00;
                  if ((prm & PARAM_FR) != 0) begin
                     for (int i = 0; i < act_len; i++) fb[i] = act_bytes[i];
                     push_frame(fb, act_len, KIND_REPEAT, 1'b0);
                  end else begin
                     lk_power = (prm & PARAM_FULL_POWER) != 0;
                     lk_phase = PHASE_READY_SENT;
                     fb[0] = READY_FRAME_ID;
                     push_frame(fb, 1, KIND_READY, 1'b1);
                  end
               end
            end else if (c[7:5] == HEAD_U_FRAME) begin
               if (c[4:0] == U_RSET) begin
                  reset_link();
                  w = (l > 16'd1 && p < lk_window) ? p[2:0] : lk_window;
                  if (w == 3'd0) w = 3'd1;
                  lk_window = w;
                  lk_open   = 1'b1;
                  lk_phase  = PHASE_ESTABLISHED;
                  fb[0] = U_UA_BYTE;
                  fb[1] = {5'd0, w};
                  fb[2] = 8'h00;
                  push_frame(fb, 3, KIND_UA, 1'b0);
               end
            end else if (c[7:5] != HEAD_S_FRAME && lk_open) begin
               // I-frame on an open link
               if (c[5:3] != lk_nr) begin
                  push_beat({S_REJ_HEAD, lk_nr}, 1'b1, KIND_REJ, 9'd0);
               end else begin
                  lk_nr++;
                  dlen = int'(l) - 1;
                  if (dlen == 0) begin
                     push_beat({S_RR_HEAD, lk_nr}, 1'b1, KIND_RR, 9'd0);
                  end else begin
                     alen = (dlen > int'(APP_LEN_MAX)) ? APP_LEN_MAX : dlen[8:0];
                     push_beat({I_HEAD, lk_ns, lk_nr}, 1'b1, KIND_IHEADER, alen);
                     lk_ns++;
                  end
               end
            end
         end
         default: begin
            // unknown request type: ignored
         end
      endcase
   endfunction

   // --------------------------------------------------------------------------
   // Response side: random ready, forced hold-off, checking
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left--;
      end else if (hold_request) begin
         // long hold-off so that the job queue fills and the request side stalls
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
   end

   function automatic void check_field(input string fname, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, fname, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      tx_beat_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (tx_pending.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual byte 0x%0h kind %0d",
                     $time, rsp_ch.tx_byte, rsp_ch.send_kind);
            errors++;
         end else begin
            want = tx_pending.pop_front();
            check_field("tx_byte", 16'(want.tx_byte), 16'(rsp_ch.tx_byte));
            check_field("tx_last", 16'(want.tx_last), 16'(rsp_ch.tx_last));
            check_field("send_kind", 16'(want.send_kind), 16'(rsp_ch.send_kind));
            check_field("app_length", 16'(want.app_length), 16'(rsp_ch.app_length));
            check_field("link_state", 16'(want.link_state), 16'(rsp_ch.link_state));
            check_field("full_power_mode", 16'(want.full_power_mode),
                        16'(rsp_ch.full_power_mode));
         end
      end
   end

   // watchdog: any run of cycles without a transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // --------------------------------------------------------------------------
   // Request side
   // --------------------------------------------------------------------------
   // Offers one request and waits for the handshake. Valid is only lowered
   // on an idle gap, so back-to-back requests keep it high.
   task automatic send_item(input logic [1:0] t, input logic [7:0] c,
                            input logic [7:0] p, input logic [15:0] l);
      int unsigned seen;
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.req_type     <= t;
      req_ch.control_byte <= c;
      req_ch.first_param  <= p;
      req_ch.frame_length <= l;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      seen = beats_predicted;
      compute_tx_bytes(t, c, p, l);
      if (beats_predicted != seen) answered_items++;
   endtask

   // sender pause until the engine has delivered everything owed
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (tx_pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // registers are only written with the engine idle
   task automatic apply_config(input cfg_type c);
      wait_drained();
      write_csr(CSR_MAX_WINDOW, CSR_DATA_W'(c.max_window));
      write_csr(CSR_LOCAL_VERSION, CSR_DATA_W'(c.local_version));
      write_csr(CSR_SUPPORTED_LLCS, CSR_DATA_W'(c.supported_llcs));
      write_csr(CSR_MAX_FRAME_SIZE, c.max_frame_size);
      write_csr(CSR_POWER_MODES, CSR_DATA_W'(c.power_modes));
      csr_we     <= 1'b0;
      cfg_shadow  = c;
   endtask

   function automatic logic [15:0] pick_frame_len();
      if ($urandom_range(99) < 80) return 16'($urandom_range(1, 16));
      return 16'($urandom_range(1, FRAME_LIMIT));
   endfunction

   // --------------------------------------------------------------------------
   // Tests
   // --------------------------------------------------------------------------
   // requests that must leave the response channel silent
   task automatic test_silent_requests();
      send_item(REQ_DEACTIVATE, 8'h00, 8'h00, 16'd1);
      send_item(REQ_UNKNOWN, 8'hFF, 8'hFF, 16'hFFFF);
      send_item(REQ_FRAME, PWR_MODE_CTRL, 8'h00, 16'd0);
      send_item(REQ_FRAME, {I_HEAD, 3'd0, 3'd0}, 8'h00, 16'd5);  // link down
      send_item(REQ_FRAME, PWR_MODE_CTRL, PARAM_FR, 16'd2);      // nothing stored
      send_item(REQ_FRAME, 8'h7F, 8'h00, 16'd2);                 // not a power frame
   endtask

   // ACT layer: sync, repeat, ready, power flag, drops
   task automatic test_act_layer();
      send_item(REQ_ACTIVATE, 8'h00, 8'h00, 16'd0);
      send_item(REQ_FRAME, PWR_MODE_CTRL, PARAM_FR, 16'd2);      // repeats the sync
      send_item(REQ_FRAME, PWR_MODE_CTRL, 8'hFF, 16'd1);         // parameter forced to 0
      send_item(REQ_FRAME, PWR_MODE_CTRL, PARAM_FULL_POWER, 16'(FRAME_LIMIT));
      send_item(REQ_FRAME, PWR_MODE_CTRL, 8'hFF, 16'd2);         // repeats the ready frame
      send_item(REQ_FRAME, PWR_MODE_CTRL, 8'h00, 16'(FRAME_LIMIT + 1));
      send_item(REQ_FRAME, 8'hFF, 8'hFF, 16'hFFFF);
      send_item(REQ_FRAME, 8'h00, 8'h00, 16'd1);
   endtask

   // SHDLC: window negotiation and modulo-8 sequencing
   task automatic test_shdlc_layer();
      send_item(REQ_FRAME, RSET_CTRL, 8'h02, 16'd1);             // no proposal
      send_item(REQ_FRAME, RSET_CTRL, 8'h00, 16'd2);             // zero becomes one
      send_item(REQ_FRAME, RSET_CTRL, 8'hFF, 16'd2);             // clamped
      send_item(REQ_FRAME, RSET_CTRL, 8'h03, 16'd2);
      send_item(REQ_FRAME, {HEAD_U_FRAME, 5'h00}, 8'h00, 16'd1);
      send_item(REQ_FRAME, {HEAD_S_FRAME, 5'h1F}, 8'h00, 16'd1);
      send_item(REQ_FRAME, {I_HEAD, 3'd0, 3'd7}, 8'h00, 16'd1);  // RR
      send_item(REQ_FRAME, {I_HEAD, 3'd1, 3'd0}, 8'hAA, 16'(FRAME_LIMIT));
      send_item(REQ_FRAME, {I_HEAD, 3'd5, 3'd0}, 8'h00, 16'd4);  // out of sequence
      send_item(REQ_FRAME, {I_HEAD, 3'd2, 3'd3}, 8'h55, 16'd3);
      send_item(REQ_FRAME, PWR_MODE_CTRL, PARAM_FR, 16'd2);      // store cleared by RSET
      send_item(REQ_DEACTIVATE, 8'hFF, 8'hFF, 16'hFFFF);
      send_item(REQ_FRAME, {I_HEAD, 3'd0, 3'd0}, 8'h00, 16'd2);
   endtask

   // both ends of every register
   task automatic test_register_extremes();
      cfg_type c;
      c = '{max_window: 3'd1, local_version: 8'h00, supported_llcs: 8'h00,
            max_frame_size: 16'h0000, power_modes: 8'h00};
      apply_config(c);
      send_item(REQ_ACTIVATE, 8'hFF, 8'hFF, 16'hFFFF);
      send_item(REQ_FRAME, RSET_CTRL, 8'h00, 16'd2);
      send_item(REQ_FRAME, RSET_CTRL, 8'hFF, 16'd2);
      c = '{max_window: 3'd7, local_version: 8'hFF, supported_llcs: 8'hFF,
            max_frame_size: 16'hFFFF, power_modes: 8'hFF};
      apply_config(c);
      send_item(REQ_ACTIVATE, 8'h00, 8'h00, 16'd0);
      send_item(REQ_FRAME, RSET_CTRL, 8'h06, 16'd2);
      send_item(REQ_FRAME, RSET_CTRL, 8'hFF, 16'd2);
   endtask

   // response side held off while requests keep coming, then a full drain
   task automatic test_backpressure();
      wait_drained();
      src_idle_pct  = 0;
      hold_request  = 1'b1;
      repeat (10) send_item(REQ_ACTIVATE, 8'($urandom), 8'($urandom), 16'($urandom));
      wait_drained();
   endtask

   // well-formed session: activate, power mode, RSET and a run of I-frames
   task automatic run_session();
      logic [7:0] p;
      logic [2:0] ns;
      send_item(REQ_ACTIVATE, 8'($urandom), 8'($urandom), 16'($urandom));
      if ($urandom_range(99) < 70) begin
         p = 8'($urandom);
         if ($urandom_range(99) < 75) p = p & ~PARAM_FR;
         send_item(REQ_FRAME, PWR_MODE_CTRL, p, 16'($urandom_range(1, 3)));
      end
      if ($urandom_range(99) < 30)
         send_item(REQ_FRAME, PWR_MODE_CTRL, 8'($urandom) | PARAM_FR,
                   16'($urandom_range(2, 4)));
      p = ($urandom_range(99) < 60) ? 8'($urandom_range(0, 7)) : 8'($urandom);
      send_item(REQ_FRAME, RSET_CTRL, p, 16'($urandom_range(1, 4)));
      repeat ($urandom_range(2, 12)) begin
         ns = lk_nr;
         if ($urandom_range(99) >= 88) ns = 3'($urandom_range(0, 7));
         send_item(REQ_FRAME, {I_HEAD, ns, 3'($urandom)}, 8'($urandom), pick_frame_len());
      end
      if ($urandom_range(99) < 25)
         send_item(REQ_DEACTIVATE, 8'($urandom), 8'($urandom), 16'($urandom));
   endtask

   // noise: any request type, any byte, any length including drops
   task automatic send_noise();
      logic [1:0]  t;
      logic [15:0] l;
      t = ($urandom_range(99) < 60) ? REQ_FRAME : 2'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
         0:       l = 16'd0;
         1:       l = pick_frame_len();
         2:       l = 16'($urandom_range(FRAME_LIMIT + 1, 16'hFFFF));
         default: l = 16'($urandom);
      endcase
      send_item(t, 8'($urandom), 8'($urandom), l);
   endtask

   task automatic run_random(input int unsigned target);
      int unsigned stop_at;
      stop_at = answered_items + target;
      while (answered_items < stop_at) begin
         if ($urandom_range(99) < 75) run_session();
         else send_noise();
      end
   endtask

   function automatic cfg_type random_config();
      cfg_type c;
      c.max_window     = 3'($urandom_range(1, 7));
      c.local_version  = 8'($urandom);
      c.supported_llcs = 8'($urandom);
      c.max_frame_size = 16'($urandom);
      c.power_modes    = 8'($urandom);
      return c;
   endfunction

   // three idling regimes, each under its own register setting
   task automatic test_random_traffic();
      src_idle_pct  = 35;
      snk_stall_pct = 58;
      apply_config(random_config());
      run_random(120);
      src_idle_pct  = 58;
      snk_stall_pct = 35;
      apply_config(random_config());
      run_random(120);
      src_idle_pct  = 0;
      snk_stall_pct = 0;
      apply_config(CFG_RESET);
      run_random(120);
   endtask

   // --------------------------------------------------------------------------
   // Sequence
   // --------------------------------------------------------------------------
   initial begin
      // every input known from time zero
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = CSR_MAX_WINDOW;
      csr_wdata           = '0;
      req_ch.valid        = 1'b0;
      req_ch.req_type     = REQ_DEACTIVATE;
      req_ch.control_byte = 8'h00;
      req_ch.first_param  = 8'h00;
      req_ch.frame_length = 16'd0;
      rsp_ch.ready        = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part runs under the first idling regime
      src_idle_pct  = 35;
      snk_stall_pct = 58;
      test_silent_requests();
      test_act_layer();
      test_shdlc_layer();
      test_register_extremes();
      test_backpressure();
      test_random_traffic();

      wait_drained();
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
